[rtl/bmlt_pkg.sv]
// Shared types, constants and band-edge functions for the battery median level tracker.
package bmlt_pkg;

  localparam int unsigned DATA_W     = 12;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned MARGIN_W   = 6;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned WINDOW_DEF = 6;
  localparam int unsigned LEVELS_DEF = 5;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 24;

  localparam logic [EDGE_W-1:0] EDGE_NONE = 16'hFFFF;

  localparam logic [EDGE_W-1:0] UP_BASE [8] = '{
    16'h01D3, 16'h0207, 16'h0234, 16'h0262,
    EDGE_NONE, EDGE_NONE, EDGE_NONE, EDGE_NONE
  };
  localparam logic [EDGE_W-1:0] DOWN_BASE [8] = '{
    16'h0000, 16'h01DA, 16'h0207, 16'h0234,
    16'h0262, EDGE_NONE, EDGE_NONE, EDGE_NONE
  };

  localparam logic [DATA_W-1:0]   USB_THRESH_RST = 12'h140;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 6'd10;

  // Word index of the APB registers
  typedef enum logic {
    REG_USB_THRESH  = 1'b0,
    REG_BAND_MARGIN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] median;
    logic [LVL_W-1:0]  level;
    logic              low;
    logic              pwr_down;
    logic              usb;
  } result_t;

  function automatic logic [EDGE_W-1:0] up_edge(input logic [LVL_W-1:0] lvl,
                                                input logic [MARGIN_W-1:0] m);
    logic [EDGE_W-1:0] e;
    e = UP_BASE[lvl];
    if (lvl == '0 || e == EDGE_NONE) begin
      return e;
    end
    return e + EDGE_W'(m);
  endfunction

  function automatic logic [EDGE_W-1:0] down_edge(input logic [LVL_W-1:0] lvl,
                                                  input logic [MARGIN_W-1:0] m);
    logic [EDGE_W-1:0] e;
    e = DOWN_BASE[lvl];
    if (lvl == '0 || e == EDGE_NONE) begin
      return e;
    end
    if (e > EDGE_W'(m)) begin
      return e - EDGE_W'(m);
    end
    return '0;
  endfunction

endpackage

[rtl/bmlt_cell.sv]
// One cell of the sorted insertion chain: holds one sample, shifts right on insert.
module bmlt_cell
  import bmlt_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              occ_i,
  input  logic [DATA_W-1:0] sample_i,
  input  logic [DATA_W-1:0] left_val_i,
  input  logic              left_gt_i,
  output logic [DATA_W-1:0] val_o,
  output logic              gt_o,
  output logic [DATA_W-1:0] next_o
);

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;

  // empty cells count as larger than any sample
  assign gt_o = !occ_i || (val_q > sample_i);

  always_comb begin
    if (!gt_o) begin
      val_d = val_q;
    end else if (!left_gt_i) begin
      val_d = sample_i;
    end else begin
      val_d = left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o  = val_q;
  assign next_o = val_d;

endmodule

[rtl/bmlt_level.sv]
// Hysteresis level update and registered result stage.
module bmlt_level
  import bmlt_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                eval_valid_i,
  input  logic [DATA_W-1:0]   med_i,
  input  logic                usb_i,
  input  logic [MARGIN_W-1:0] margin_i,
  input  logic                out_ready_i,
  output logic                eval_ready_o,
  output logic                out_valid_o,
  output result_t             result_o,
  output logic [LVL_W-1:0]    level_o
);

  logic [LVL_W-1:0]  level_q, level_d;
  logic [LVL_W-1:0]  lvl_n;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  logic [EDGE_W-1:0] med_e;
  logic              fire;

  assign med_e        = EDGE_W'(med_i);
  assign eval_ready_o = !out_valid_q || out_ready_i;
  assign fire         = eval_valid_i && eval_ready_o;

  // fall at most one step, rise through every band edge passed
  always_comb begin
    lvl_n = level_q;
    if (med_e <= down_edge(level_q, margin_i)) begin
      if (level_q != '0) begin
        lvl_n = level_q - LVL_W'(1);
      end
    end else begin
      for (int l = 0; l < int'(LEVELS) - 1; l++) begin
        if (lvl_n == LVL_W'(l) && med_e >= up_edge(LVL_W'(l), margin_i)) begin
          lvl_n = LVL_W'(l + 1);
        end
      end
    end
  end

  always_comb begin
    res_d.median   = med_i;
    res_d.level    = lvl_n;
    res_d.low      = (lvl_n <= LVL_W'(1));
    res_d.pwr_down = (lvl_n == '0);
    res_d.usb      = usb_i;
    level_d        = fire ? lvl_n : level_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LVL_W'(LEVELS - 1);
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign level_o     = level_q;

endmodule

[rtl/battery_median_level_tracker.sv]
// Top level: insertion chain, window counter, config registers and result stream.
//
// Usage:
//   s_axis carries one ADC scan per item: tdata[11:0] battery sample,
//   tdata[23:12] USB sense sample. Samples enter a chain of WINDOW cells that
//   keeps them sorted, one sample per cycle while s_axis_tready is high. The
//   item that completes a window captures the upper median and the USB compare;
//   the level update is registered in the result stage once that stage can take
//   it, and m_axis presents one result item. Windows that are not complete produce nothing.
//   m_axis_tvalid rises once the result register takes the captured median.
//   Throughput: one item per cycle; s_axis_tready drops only while a captured
//   median waits behind a stalled result that m_axis has not taken.
//   When m_axis stalls the result holds in its output register; input keeps
//   flowing until the next window completes.
//   Reset clears the window count, starts the level at full (LEVELS-1), and
//   loads usb_threshold = 320 and band_margin = 10. The sample cells are not
//   cleared; every cell is written before a window is evaluated.
//   APB: usb_threshold at 0x0, band_margin at 0x4; write while idle.
module battery_median_level_tracker
  import bmlt_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [11:0] battery_sample, [23:12] usb_sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [11:0] median_value, [14:12] battery_level, [15] charge_low,
  // [16] power_down, [17] usb_present, [23:18] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int unsigned CNT_W = $clog2(WINDOW);
  localparam int unsigned MID   = WINDOW / 2;

  logic [DATA_W-1:0]   bat_sample, usb_sample;
  logic                accept, last;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W-1:0]   med_q;
  logic                usb_q;
  logic                eval_q, eval_d;
  logic                eval_ready;
  logic [DATA_W-1:0]   thresh_q;
  logic [MARGIN_W-1:0] margin_q;
  logic                cfg_wr;
  reg_idx_e            reg_idx;
  result_t             result;
  logic [LVL_W-1:0]    level;

  logic [DATA_W-1:0] cell_val  [WINDOW];
  logic [DATA_W-1:0] cell_next [WINDOW];
  logic              cell_gt   [WINDOW];

  assign bat_sample    = s_axis_tdata[DATA_W-1:0];
  assign usb_sample    = s_axis_tdata[2*DATA_W-1:DATA_W];
  assign s_axis_tready = !eval_q || eval_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last          = (cnt_q == CNT_W'(WINDOW - 1));

  // sorted insertion chain
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic              left_gt;
    if (k == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[k-1];
      assign left_gt  = cell_gt[k-1];
    end
    bmlt_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .occ_i      (CNT_W'(k) < cnt_q),
      .sample_i   (bat_sample),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .val_o      (cell_val[k]),
      .gt_o       (cell_gt[k]),
      .next_o     (cell_next[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
    end
    if (accept && last) begin
      eval_d = 1'b1;
    end else if (eval_ready) begin
      eval_d = 1'b0;
    end else begin
      eval_d = eval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      eval_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      eval_q <= eval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      med_q <= cell_next[MID];
      usb_q <= (usb_sample >= thresh_q);
    end
  end

  bmlt_level #(
    .LEVELS (LEVELS)
  ) u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eval_valid_i (eval_q),
    .med_i        (med_q),
    .usb_i        (usb_q),
    .margin_i     (margin_q),
    .out_ready_i  (m_axis_tready),
    .eval_ready_o (eval_ready),
    .out_valid_o  (m_axis_tvalid),
    .result_o     (result),
    .level_o      (level)
  );

  assign m_axis_tdata = {6'b0, result.usb, result.pwr_down, result.low,
                         result.level, result.median};

  // APB registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= USB_THRESH_RST;
      margin_q <= MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_USB_THRESH:  thresh_q <= pwdata[DATA_W-1:0];
        REG_BAND_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_USB_THRESH:  prdata = APB_DW'(thresh_q);
      REG_BAND_MARGIN: prdata = APB_DW'(margin_q);
      default:         prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_level_falls_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level < $past(level)) |-> (level == $past(level) - LVL_W'(1)))
    else $error("level fell by more than one step");

  a_window_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (cnt_q == '0 && eval_q))
    else $error("window completion did not restart count and start evaluation");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW - 1))
    else $error("sample count out of range");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LVL_W'(LEVELS - 1))
    else $error("level out of range");
`endif

endmodule
